// ----- rtl/core/pcmd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcmd_pkg
// Shared types and constants for the pulse capture mode detector: opcodes,
// mode codes, configuration register indexes, run limits and the result type.
// ----------------------------------------------------------------------------
package pcmd_pkg;

   // Default timing parameters.
   localparam int US_PER_RELOAD_DEF = 10000;
   localparam int TICKS_PER_US_DEF  = 4;

   // Field widths.
   localparam int OPCODE_W     = 2;
   localparam int CAPTURE_W    = 16;
   localparam int MODE_W       = 2;
   localparam int WIDTH_W      = 30;
   localparam int BRIGHT_W     = 7;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int HIGH_CNT_W   = 16;
   localparam int LOW_CNT_W    = 8;
   // Holds US_PER_RELOAD times the saturated high tick count for any legal period.
   localparam int HIGH_US_W    = 32;

   // Saturated width in microseconds.
   localparam logic [WIDTH_W-1:0] WIDTH_SAT = 30'd655369999;

   // Run limits: a run longer than the limit changes the mode.
   localparam logic [3:0] START_RUN_LIMIT = 4'd9;
   localparam logic [4:0] BAD_RUN_LIMIT   = 5'd20;
   localparam logic [3:0] SHORT_RUN_LIMIT = 4'd10;

   // Configuration register reset values.
   localparam logic [15:0] START_LOW_RST  = 16'd1090;
   localparam logic [15:0] START_HIGH_RST = 16'd1135;
   localparam logic [15:0] VALID_MIN_RST  = 16'd1000;
   localparam logic [15:0] VALID_MAX_RST  = 16'd2000;
   localparam logic [7:0]  IDLE_LOW_RST   = 8'd55;
   localparam logic [6:0]  BRIGHT_MAX_RST = 7'd64;

   // Request opcodes.
   typedef enum logic [OPCODE_W-1:0] {
      OP_CAPTURE    = 2'd0,
      OP_TICK       = 2'd1,
      OP_MODE_RESET = 2'd2,
      OP_CLEAR_FLAG = 2'd3
   } opcode_type;

   // Mode codes as reported on the result channel.
   localparam logic [MODE_W-1:0] MODE_INVALID = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PWM     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SWITCH  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_START_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALID_MIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALID_MAX  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LOW   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHT_MAX = 3'd5;

   // One result as held in the output and skid registers.
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [WIDTH_W-1:0]  width;
      logic [BRIGHT_W-1:0] brightness;
      logic                updated;
   } result_type;

endpackage

// ----- rtl/core/pulse_capture_mode_detector.sv -----
// ----------------------------------------------------------------------------
// pulse_capture_mode_detector
// Pulse width measurement and mode detection from edge captures and ticks.
// ----------------------------------------------------------------------------
// Each request is either a capture edge, a timer reload tick, a mode reset or
// a clear of the update flag, and produces exactly one response holding the
// mode, the last measured high width in microseconds, the switch-mode
// brightness and the update flag as they stand after that request. A request
// is handled by a single pass of compare-and-count logic, so one request can
// be accepted every clock unless the request side stalls; its response is
// registered. An output register and a skid register decouple the two sides,
// so a new request is accepted while one response waits, and the request side
// stalls only while both hold a response. Configuration writes take effect at
// the next clock and are meant to be made while no request is in flight.
module pulse_capture_mode_detector #(
   parameter int US_PER_RELOAD = pcmd_pkg::US_PER_RELOAD_DEF,
   parameter int TICKS_PER_US  = pcmd_pkg::TICKS_PER_US_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [pcmd_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [pcmd_pkg::CAPTURE_W-1:0]       req_capture_count,
   input  logic                                 req_pin_level,
   // Response channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pcmd_pkg::MODE_W-1:0]          rsp_mode,
   output logic [pcmd_pkg::WIDTH_W-1:0]         rsp_measured_width,
   output logic [pcmd_pkg::BRIGHT_W-1:0]        rsp_brightness,
   output logic                                 rsp_width_updated,
   // Configuration write port.
   input  logic                                 csr_wr_en,
   input  logic [pcmd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pcmd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import pcmd_pkg::*;

   // Reciprocal for the tick-to-microsecond division of a 16-bit magnitude.
   localparam int RECIP_SHIFT = CAPTURE_W + 5;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + TICKS_PER_US - 1) / TICKS_PER_US);
   localparam logic [HIGH_US_W-1:0] US_STEP = HIGH_US_W'(US_PER_RELOAD);
   localparam int SUM_W = HIGH_US_W + 2;

   // Configuration registers.
   logic [15:0]         start_low_ff, start_high_ff, valid_min_ff, valid_max_ff;
   logic [7:0]          idle_low_ff;
   logic [BRIGHT_W-1:0] bright_max_ff;

   // Block state and next values.
   logic                  expect_falling_ff, expect_falling_in;
   logic [CAPTURE_W-1:0]  rise_capture_ff, rise_capture_in;
   logic [WIDTH_W-1:0]    width_ff, width_in;
   logic [HIGH_CNT_W-1:0] high_reloads_ff, high_reloads_in;
   logic [HIGH_US_W-1:0]  high_us_ff, high_us_in;
   logic [LOW_CNT_W-1:0]  low_reloads_ff, low_reloads_in;
   logic                  width_invalid_ff, width_invalid_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [3:0]            start_run_ff, start_run_in;
   logic [4:0]            bad_run_ff, bad_run_in;
   logic [3:0]            short_run_ff, short_run_in;
   logic [BRIGHT_W-1:0]   bright_ff, bright_in;
   logic                  update_ff, update_in;

   // Output and skid registers.
   logic       out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff, result;

   logic req_take, out_free;
   opcode_type op;

   // Width arithmetic for a falling edge.
   logic signed [CAPTURE_W:0]        cap_diff;
   logic        [CAPTURE_W-1:0]      diff_mag;
   logic        [CAPTURE_W+RECIP_W-1:0] quot_prod;
   logic        [CAPTURE_W-1:0]      diff_us;
   logic signed [SUM_W-1:0]          width_sum;
   logic        [WIDTH_W-1:0]        width_new;

   assign op       = opcode_type'(req_opcode);
   assign req_stall = skid_valid_ff;
   assign req_take = req_valid & ~skid_valid_ff;
   assign out_free = ~out_valid_ff | ~rsp_stall;

   // Signed tick difference, divided toward zero by the tick rate.
   assign cap_diff  = $signed({1'b0, req_capture_count}) - $signed({1'b0, rise_capture_ff});
   assign diff_mag  = cap_diff[CAPTURE_W] ? CAPTURE_W'(-cap_diff) : cap_diff[CAPTURE_W-1:0];
   assign quot_prod = diff_mag * RECIP;
   assign diff_us   = quot_prod[RECIP_SHIFT +: CAPTURE_W];
   assign width_sum = $signed({2'b00, high_us_ff})
                    + (cap_diff[CAPTURE_W] ? -$signed({{(SUM_W-CAPTURE_W){1'b0}}, diff_us})
                                           :  $signed({{(SUM_W-CAPTURE_W){1'b0}}, diff_us}));
   assign width_new = (width_sum[SUM_W-1] || width_sum > $signed(SUM_W'(WIDTH_SAT)))
                    ? WIDTH_SAT : width_sum[WIDTH_W-1:0];

   // Next state for one request.
   always_comb begin
      expect_falling_in = expect_falling_ff;
      rise_capture_in   = rise_capture_ff;
      width_in          = width_ff;
      high_reloads_in   = high_reloads_ff;
      high_us_in        = high_us_ff;
      low_reloads_in    = low_reloads_ff;
      width_invalid_in  = width_invalid_ff;
      mode_in           = mode_ff;
      start_run_in      = start_run_ff;
      bad_run_in        = bad_run_ff;
      short_run_in      = short_run_ff;
      bright_in         = bright_ff;
      update_in         = update_ff;

      unique case (op)
         OP_CAPTURE: begin
            if (!expect_falling_ff) begin
               // Rising edge: remember the capture and start a high period.
               rise_capture_in   = req_capture_count;
               expect_falling_in = 1'b1;
               high_reloads_in   = '0;
               high_us_in        = '0;
               low_reloads_in    = '0;
            end else begin
               // Falling edge: measure unless the rise was missed.
               if (!width_invalid_ff) begin
                  width_in = width_new;
               end else begin
                  width_invalid_in = 1'b0;
               end
               expect_falling_in = 1'b0;
               high_reloads_in   = '0;
               high_us_in        = '0;
               low_reloads_in    = '0;

               // Short pulses in switch mode.
               if (mode_in == MODE_SWITCH && 32'(width_in) < 32'(US_PER_RELOAD)) begin
                  short_run_in = short_run_ff + 4'd1;
                  if (short_run_in > SHORT_RUN_LIMIT) begin
                     short_run_in = '0;
                     mode_in      = MODE_INVALID;
                     bright_in    = '0;
                  end
               end else begin
                  short_run_in = '0;
               end

               // Start-width pulses lead into pulse-width mode.
               if (mode_in != MODE_PWM) begin
                  if (width_in > WIDTH_W'(start_low_ff) && width_in < WIDTH_W'(start_high_ff)) begin
                     start_run_in = start_run_ff + 4'd1;
                     if (start_run_in > START_RUN_LIMIT) begin
                        mode_in      = MODE_PWM;
                        bright_in    = '0;
                        start_run_in = '0;
                     end
                  end else begin
                     start_run_in = '0;
                  end
               end

               // Out-of-range pulses in pulse-width mode.
               if (mode_in == MODE_PWM && (width_in < WIDTH_W'(valid_min_ff) ||
                                           width_in > WIDTH_W'(valid_max_ff))) begin
                  bad_run_in = bad_run_ff + 5'd1;
                  if (bad_run_in > BAD_RUN_LIMIT) begin
                     bad_run_in = '0;
                     mode_in    = MODE_INVALID;
                     bright_in  = '0;
                  end
               end else begin
                  bad_run_in = '0;
               end

               update_in = 1'b1;
            end
         end
         OP_TICK: begin
            if (req_pin_level) begin
               if (expect_falling_ff) begin
                  // High tick within a pulse.
                  if (high_reloads_ff != '1) begin
                     high_reloads_in = high_reloads_ff + HIGH_CNT_W'(1);
                     high_us_in      = high_us_ff + US_STEP;
                  end
                  if (mode_ff == MODE_SWITCH) begin
                     if (bright_ff < bright_max_ff) begin
                        bright_in = bright_ff + BRIGHT_W'(1);
                     end
                  end else if (mode_ff == MODE_PWM) begin
                     if (high_reloads_in > HIGH_CNT_W'(1)) begin
                        mode_in = MODE_INVALID;
                     end
                  end
               end else begin
                  // High level without a rising edge: the pulse is lost.
                  width_invalid_in  = 1'b1;
                  expect_falling_in = 1'b1;
                  low_reloads_in    = '0;
                  high_reloads_in   = '0;
                  high_us_in        = '0;
               end
            end else begin
               if (!expect_falling_ff) begin
                  // Low tick between pulses.
                  if (low_reloads_ff != '1) begin
                     low_reloads_in = low_reloads_ff + LOW_CNT_W'(1);
                  end
                  if (mode_ff == MODE_SWITCH) begin
                     bright_in = (bright_ff >= BRIGHT_W'(2)) ? bright_ff - BRIGHT_W'(2) : '0;
                  end else if (low_reloads_in > idle_low_ff) begin
                     mode_in   = MODE_SWITCH;
                     bright_in = '0;
                  end
               end else begin
                  // Low level without a falling edge.
                  expect_falling_in = 1'b0;
                  high_reloads_in   = '0;
                  high_us_in        = '0;
                  low_reloads_in    = '0;
               end
            end
         end
         OP_MODE_RESET: begin
            mode_in = MODE_INVALID;
         end
         OP_CLEAR_FLAG: begin
            update_in = 1'b0;
         end
         default: begin
            update_in = update_ff;
         end
      endcase
   end

   // Response built from the next state.
   always_comb begin
      result.mode       = mode_in;
      result.width      = width_in;
      result.brightness = bright_in;
      result.updated    = update_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_low_ff  <= START_LOW_RST;
         start_high_ff <= START_HIGH_RST;
         valid_min_ff  <= VALID_MIN_RST;
         valid_max_ff  <= VALID_MAX_RST;
         idle_low_ff   <= IDLE_LOW_RST;
         bright_max_ff <= BRIGHT_MAX_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_LOW:  start_low_ff  <= csr_wdata;
            CSR_START_HIGH: start_high_ff <= csr_wdata;
            CSR_VALID_MIN:  valid_min_ff  <= csr_wdata;
            CSR_VALID_MAX:  valid_max_ff  <= csr_wdata;
            CSR_IDLE_LOW:   idle_low_ff   <= csr_wdata[7:0];
            CSR_BRIGHT_MAX: bright_max_ff <= csr_wdata[BRIGHT_W-1:0];
            default: begin
               start_low_ff <= start_low_ff;
            end
         endcase
      end
   end

   // Block state, updated on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_falling_ff <= 1'b0;
         rise_capture_ff   <= '0;
         width_ff          <= '0;
         high_reloads_ff   <= '0;
         high_us_ff        <= '0;
         low_reloads_ff    <= '0;
         width_invalid_ff  <= 1'b0;
         mode_ff           <= MODE_INVALID;
         start_run_ff      <= '0;
         bad_run_ff        <= '0;
         short_run_ff      <= '0;
         bright_ff         <= '0;
         update_ff         <= 1'b0;
      end else if (req_take) begin
         expect_falling_ff <= expect_falling_in;
         rise_capture_ff   <= rise_capture_in;
         width_ff          <= width_in;
         high_reloads_ff   <= high_reloads_in;
         high_us_ff        <= high_us_in;
         low_reloads_ff    <= low_reloads_in;
         width_invalid_ff  <= width_invalid_in;
         mode_ff           <= mode_in;
         start_run_ff      <= start_run_in;
         bad_run_ff        <= bad_run_in;
         short_run_ff      <= short_run_in;
         bright_ff         <= bright_in;
         update_ff         <= update_in;
      end
   end

   // Output register with a skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_free) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_ff <= skid_ff;
         end
      end else if (req_take) begin
         if (out_free) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_mode           = out_ff.mode;
   assign rsp_measured_width = out_ff.width;
   assign rsp_brightness     = out_ff.brightness;
   assign rsp_width_updated  = out_ff.updated;

endmodule
